@@ src/mark_sweep_object_table_unit_macros.svh @@
// assertion macros for the object table unit
`ifndef MARK_SWEEP_OBJECT_TABLE_UNIT_MACROS_SVH
`define MARK_SWEEP_OBJECT_TABLE_UNIT_MACROS_SVH

// check that holds at every clock edge out of reset
`define MSOT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that an event implies a condition on the next edge
`define MSOT_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

@@ src/msot_pkg.sv @@
// shared types and constants of the object table unit
package msot_pkg;

	localparam int MaxObjects = 32;
	localparam int AddrBits   = 32;
	localparam int SizeBits   = 32;
	localparam int CountBits  = 16;
	localparam int BytesBits  = 38;
	localparam int SlotBits   = $clog2(MaxObjects);
	localparam int TotalBits  = $clog2(MaxObjects + 1);
	localparam int InBits     = 96;
	localparam int OutBits    = 96;

	typedef enum logic [2:0] {
		KIND_ALLOC   = 3'd0,
		KIND_RETAIN  = 3'd1,
		KIND_RELEASE = 3'd2,
		KIND_ADD_REF = 3'd3,
		KIND_REM_REF = 3'd4,
		KIND_COLLECT = 3'd5,
		KIND_DETECT  = 3'd6,
		KIND_DESTROY = 3'd7
	} kind_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic mark;
		logic peel;
		logic count;
		logic sweep;
		logic final_push;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		kind_t kind;
		logic  enabled;
		logic  idx_last;
		logic  pass_changed;
		logic  sweep_adv;
		logic  out_free;
	} stat_t;

endpackage

@@ src/mark_sweep_object_table_unit.sv @@
// top level of the object table unit
// Table of 32 managed objects with a reference matrix; one request a time. Table requests go
// through accept, associative lookup and update, and result. An enabled collect walks the
// matrix one row a cycle, in marking passes repeated until no mark spreads (up to 32 passes),
// then a pass that settles the totals and a sweep that sends one result per freed object, so
// that every result already carries the final totals. Detect-cycles peels objects with no live
// successor, pass by pass, until nothing changes. Destroy takes the count and sweep passes.
// A stalled output holds the sweep in place.
module mark_sweep_object_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,  // collector_enabled
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [msot_pkg::InBits-1:0]  s_tdata,    // address, target_address, size
	input  logic [2:0]                   s_tuser,    // kind
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [msot_pkg::OutBits-1:0] m_tdata,    // ok, slot, freed_address,
	                                                 // collected_count, cycle_found,
	                                                 // object_count, held_bytes
	output logic                         m_tuser,    // freed_flag
	output logic                         m_tlast     // last
);

	msot_pkg::cmd_t  cmd;
	msot_pkg::stat_t stat;

	// sequencer
	msot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table and walks
	msot_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ src/msot_ctrl.sv @@
// controller state machine of the object table unit
module msot_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  msot_pkg::stat_t stat,
	output msot_pkg::cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_MARK  = 7'b0000100,
		S_PEEL  = 7'b0001000,
		S_COUNT = 7'b0010000,
		S_SWEEP = 7'b0100000,
		S_FINAL = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (stat.kind)
					msot_pkg::KIND_COLLECT: state_d = stat.enabled ? S_MARK : S_FINAL;
					msot_pkg::KIND_DETECT:  state_d = S_PEEL;
					msot_pkg::KIND_DESTROY: state_d = S_COUNT;
					default:                state_d = S_FINAL;
				endcase
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (stat.idx_last && !stat.pass_changed) state_d = S_COUNT;
			end
			S_PEEL: begin
				cmd.peel = 1'b1;
				if (stat.idx_last && !stat.pass_changed) state_d = S_FINAL;
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				if (stat.idx_last) state_d = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.idx_last && stat.sweep_adv) state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.final_push = 1'b1;
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/msot_dp.sv @@
// datapath of the object table unit: table, edges, walks and result register
`include "mark_sweep_object_table_unit_macros.svh"

module msot_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic [msot_pkg::InBits-1:0]   s_tdata,
	input  logic [2:0]                    s_tuser,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [msot_pkg::OutBits-1:0]  m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  msot_pkg::cmd_t                cmd,
	output msot_pkg::stat_t               stat
);

	localparam int N  = msot_pkg::MaxObjects;
	localparam int SB = msot_pkg::SlotBits;
	localparam int AB = msot_pkg::AddrBits;
	localparam int ZB = msot_pkg::SizeBits;
	localparam int CB = msot_pkg::CountBits;
	localparam int BB = msot_pkg::BytesBits;
	localparam int TB = msot_pkg::TotalBits;

	localparam logic [CB-1:0] CountMax = {CB{1'b1}};
	localparam logic [BB-1:0] BytesMax = {BB{1'b1}};
	localparam logic [SB-1:0] LastIdx  = SB'(N - 1);

	// configuration and latched request
	logic                 en_q;
	msot_pkg::kind_t      kind_q;
	logic [AB-1:0]        addr_q, tgt_q;
	logic [ZB-1:0]        size_q;

	// object table
	logic [AB-1:0]        obj_addr_q [N];
	logic [ZB-1:0]        obj_size_q [N];
	logic [CB-1:0]        ext_cnt_q  [N];
	logic [N-1:0]         active_q;
	logic [N-1:0]         edge_q     [N];
	logic [TB-1:0]        total_q;
	logic [BB-1:0]        bytes_q;

	// walk state
	logic [N-1:0]         live_q, marked_q, doom_q;
	logic                 changed_q;
	logic [SB-1:0]        idx_q;
	logic [TB-1:0]        n_q;
	logic                 ok_q, cf_q;
	logic [SB-1:0]        slot_q;

	// result register
	logic                 mvalid_q, mfreed_q, mlast_q;
	logic [msot_pkg::OutBits-1:0] mdata_q;

	// associative lookups and first free slot
	logic                 found_a, found_b, free_found;
	logic [SB-1:0]        a_idx, b_idx, free_idx;
	logic [N-1:0]         cnt_nz;

	always_comb begin
		found_a    = 1'b0;
		found_b    = 1'b0;
		free_found = 1'b0;
		a_idx      = '0;
		b_idx      = '0;
		free_idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			cnt_nz[i] = ext_cnt_q[i] != '0;
			if (active_q[i] && obj_addr_q[i] == addr_q) begin
				found_a = 1'b1;
				a_idx   = SB'(i);
			end
			if (active_q[i] && obj_addr_q[i] == tgt_q) begin
				found_b = 1'b1;
				b_idx   = SB'(i);
			end
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SB'(i);
			end
		end
		found_a = found_a && addr_q != '0;
		found_b = found_b && tgt_q != '0;
	end

	// success of a table operation
	logic exec_ok;
	logic alloc_hit;

	always_comb begin
		unique case (kind_q) inside
			msot_pkg::KIND_ALLOC:   exec_ok = en_q && addr_q != '0 && free_found;
			msot_pkg::KIND_RETAIN:  exec_ok = found_a;
			msot_pkg::KIND_RELEASE: exec_ok = found_a && ext_cnt_q[a_idx] != '0;
			msot_pkg::KIND_ADD_REF, msot_pkg::KIND_REM_REF: exec_ok = found_a && found_b;
			msot_pkg::KIND_COLLECT: exec_ok = en_q;
			msot_pkg::KIND_DETECT, msot_pkg::KIND_DESTROY: exec_ok = 1'b1;
			default: exec_ok = 1'b0;
		endcase
	end

	assign alloc_hit = cmd.exec && exec_ok && kind_q == msot_pkg::KIND_ALLOC;

	// one step of the mark and peel walks
	logic [N-1:0] sel, row_live, mark_next, live_peel;
	logic         peel_hit, step_ch, idx_last, out_free, doom_bit, load_freed, load_final;
	logic [BB:0]  bytes_sum;

	always_comb begin
		sel        = {{(N-1){1'b0}}, 1'b1} << idx_q;
		row_live   = edge_q[idx_q] & live_q;
		mark_next  = marked_q[idx_q] ? (marked_q | row_live) : marked_q;
		peel_hit   = live_q[idx_q] && row_live == '0;
		live_peel  = peel_hit ? (live_q & ~sel) : live_q;
		step_ch    = cmd.mark ? (mark_next != marked_q) : peel_hit;
		idx_last   = idx_q == LastIdx;
		out_free   = !mvalid_q || m_tready;
		doom_bit   = doom_q[idx_q];
		load_freed = cmd.sweep && doom_bit && out_free;
		load_final = cmd.final_push && out_free;
		bytes_sum  = {1'b0, bytes_q} + (BB + 1)'(size_q);
	end

	assign stat.kind         = kind_q;
	assign stat.enabled      = en_q;
	assign stat.idx_last     = idx_last;
	assign stat.pass_changed = changed_q | step_ch;
	assign stat.sweep_adv    = !doom_bit || out_free;
	assign stat.out_free     = out_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= msot_pkg::kind_t'(s_tuser);
			addr_q <= s_tdata[AB-1:0];
			tgt_q  <= s_tdata[2*AB-1:AB];
			size_q <= s_tdata[2*AB+ZB-1:2*AB];
		end
	end

	// table payload
	always_ff @(posedge clk) begin
		if (cmd.exec && exec_ok) begin
			case (kind_q)
				msot_pkg::KIND_ALLOC: begin
					obj_addr_q[free_idx] <= addr_q;
					obj_size_q[free_idx] <= size_q;
					ext_cnt_q[free_idx]  <= '0;
				end
				msot_pkg::KIND_RETAIN: begin
					if (ext_cnt_q[a_idx] != CountMax) ext_cnt_q[a_idx] <= ext_cnt_q[a_idx] + 1'b1;
				end
				msot_pkg::KIND_RELEASE: begin
					ext_cnt_q[a_idx] <= ext_cnt_q[a_idx] - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// control side of the table and the walks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			total_q   <= '0;
			bytes_q   <= '0;
			for (int r = 0; r < N; r++) edge_q[r] <= '0;
			live_q    <= '0;
			marked_q  <= '0;
			doom_q    <= '0;
			changed_q <= 1'b0;
			idx_q     <= '0;
			n_q       <= '0;
			ok_q      <= 1'b0;
			cf_q      <= 1'b0;
			slot_q    <= '0;
		end else begin
			// execute the request
			if (cmd.exec) begin
				ok_q      <= exec_ok;
				slot_q    <= (kind_q == msot_pkg::KIND_ALLOC && exec_ok) ? free_idx : '0;
				cf_q      <= 1'b0;
				n_q       <= '0;
				idx_q     <= '0;
				changed_q <= 1'b0;
				live_q    <= active_q;
				marked_q  <= active_q & cnt_nz;
				doom_q    <= active_q;
				if (exec_ok) begin
					case (kind_q)
						msot_pkg::KIND_ALLOC: begin
							active_q[free_idx] <= 1'b1;
							edge_q[free_idx]   <= '0;
							for (int r = 0; r < N; r++) begin
								if (SB'(r) != free_idx) edge_q[r][free_idx] <= 1'b0;
							end
							total_q <= total_q + 1'b1;
							bytes_q <= bytes_sum[BB] ? BytesMax : bytes_sum[BB-1:0];
						end
						msot_pkg::KIND_ADD_REF: edge_q[a_idx][b_idx] <= 1'b1;
						msot_pkg::KIND_REM_REF: edge_q[a_idx][b_idx] <= 1'b0;
						default: ;
					endcase
				end
			end
			// slot index walk
			if (cmd.mark || cmd.peel || cmd.count || (cmd.sweep && (!doom_bit || out_free))) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			// mark pass: spread marks along edges
			if (cmd.mark) begin
				marked_q  <= mark_next;
				changed_q <= idx_last ? 1'b0 : (changed_q | step_ch);
				if (idx_last) doom_q <= live_q & ~mark_next;
			end
			// peel pass: drop objects with no live successor
			if (cmd.peel) begin
				live_q    <= live_peel;
				changed_q <= idx_last ? 1'b0 : (changed_q | step_ch);
				if (idx_last) cf_q <= live_peel != '0;
			end
			// count pass: settle totals before any result goes out
			if (cmd.count && doom_bit) begin
				bytes_q <= (bytes_q >= BB'(obj_size_q[idx_q])) ?
					bytes_q - BB'(obj_size_q[idx_q]) : '0;
				if (total_q != '0) total_q <= total_q - 1'b1;
			end
			// sweep pass: free one doomed slot per result
			if (load_freed) begin
				active_q[idx_q] <= 1'b0;
				edge_q[idx_q]   <= '0;
				for (int r = 0; r < N; r++) begin
					if (SB'(r) != idx_q) edge_q[r][idx_q] <= 1'b0;
				end
				n_q <= n_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (load_freed || load_final) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_freed || load_final) begin
			mfreed_q <= load_freed;
			mlast_q  <= load_final;
			mdata_q[0]     <= load_freed ? 1'b1 : ok_q;
			mdata_q[5:1]   <= load_freed ? 5'd0 : 5'(slot_q);
			mdata_q[37:6]  <= load_freed ? 32'(obj_addr_q[idx_q]) : 32'd0;
			mdata_q[43:38] <= load_freed ? 6'd0 : 6'(n_q);
			mdata_q[44]    <= load_freed ? 1'b0 : cf_q;
			mdata_q[50:45] <= 6'(total_q);
			mdata_q[88:51] <= bytes_q;
			mdata_q[msot_pkg::OutBits-1:89] <= '0;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = mfreed_q;
	assign m_tlast  = mlast_q;

	// a freed result only comes from a slot still active
	`MSOT_ASSERT(a_freed_active, !load_freed || active_q[idx_q], "freed slot not active")
	// a successful alloc leaves its slot active
	`MSOT_ASSERT_NEXT(a_alloc_active, alloc_hit, active_q[slot_q], "alloc slot not active")
	// a stalled result is never overwritten
	`MSOT_ASSERT(a_no_overwrite, !(mvalid_q && !m_tready && (load_freed || load_final)), "result overwritten")

endmodule

@@ tb/testbench.sv @@
// testbench for the object table unit: directed table then random requests, checked per field
`timescale 1ns / 1ps

module testbench;

	localparam int IdleLimit = 8000;
	localparam int NObj = msot_pkg::MaxObjects;
	localparam logic [15:0] CountMax = 16'hFFFF;
	localparam logic [37:0] BytesMax = {38{1'b1}};

	// one request and one response item
	typedef struct packed {
		msot_pkg::kind_t kind;
		logic [31:0]     address;
		logic [31:0]     target;
		logic [31:0]     size;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  slot;
		logic        freed_flag;
		logic [31:0] freed_address;
		logic [5:0]  collected_count;
		logic        cycle_found;
		logic [5:0]  object_count;
		logic [37:0] held_bytes;
		logic        last;
	} rsp_t;

	// directed row: request, whether the response is typed in, and that response
	typedef struct {
		req_t req;
		bit   fixed;
		rsp_t rsp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// shadow of the table state
	logic [31:0] tbl_addr [NObj];
	logic [31:0] tbl_size [NObj];
	logic [15:0] tbl_count [NObj];
	logic [31:0] tbl_edges [NObj];
	logic [31:0] tbl_active;
	logic [5:0]  tbl_total;
	logic [37:0] tbl_bytes;
	logic        gc_enabled;

	rsp_t        expected_rsps[$];
	rsp_t        fixed_rsp;
	bit          use_fixed;
	int          errors;
	int          idle_cycles;
	bit          hold_req;
	bit          hold_done;
	logic [31:0] used_addrs[$];

	mark_sweep_object_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// shadow state helpers
	function automatic int find_slot(logic [31:0] a);
		if (a == 0) return -1;
		for (int i = 0; i < NObj; i++)
			if (tbl_active[i] && tbl_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic rsp_t make_rsp(logic ok, logic [4:0] slot, logic ff, logic [31:0] fa,
			logic [5:0] cc, logic cf, logic last);
		rsp_t r;
		r.ok = ok; r.slot = slot; r.freed_flag = ff; r.freed_address = fa;
		r.collected_count = cc; r.cycle_found = cf; r.object_count = tbl_total;
		r.held_bytes = tbl_bytes; r.last = last;
		return r;
	endfunction

	function automatic void drop_slot(int i);
		tbl_edges[i] = '0;
		for (int j = 0; j < NObj; j++) tbl_edges[j][i] = 1'b0;
		tbl_bytes = (tbl_bytes >= 38'(tbl_size[i])) ? tbl_bytes - 38'(tbl_size[i]) : '0;
		if (tbl_total > 0) tbl_total--;
		tbl_addr[i] = '0; tbl_size[i] = '0; tbl_count[i] = '0;
		tbl_active[i] = 1'b0;
	endfunction

	// free doomed slots in order, queue a response per freed object, then the count
	function automatic void sweep_slots(logic [31:0] doom);
		logic [31:0] freed[$];
		for (int i = 0; i < NObj; i++)
			if (tbl_active[i] && doom[i]) begin
				freed.push_back(tbl_addr[i]);
				drop_slot(i);
			end
		foreach (freed[k]) expected_rsps.push_back(make_rsp(1, 0, 1, freed[k], 0, 0, 0));
		expected_rsps.push_back(make_rsp(1, 0, 0, 0, 6'(freed.size()), 0, 1));
	endfunction

	// predict the responses of one accepted request
	function automatic void predict_request(req_t q);
		int a, b, i;
		logic [31:0] live, marked, nxt;
		bit changed;
		case (q.kind)
			msot_pkg::KIND_ALLOC: begin
				i = 0;
				while (i < NObj && tbl_active[i]) i++;
				if (!gc_enabled || q.address == 0 || i >= NObj) begin
					expected_rsps.push_back(make_rsp(0, 0, 0, 0, 0, 0, 1));
				end else begin
					tbl_addr[i] = q.address; tbl_size[i] = q.size; tbl_count[i] = '0;
					tbl_active[i] = 1'b1;
					tbl_edges[i] = '0;
					for (int j = 0; j < NObj; j++) tbl_edges[j][i] = 1'b0;
					tbl_total++;
					tbl_bytes = (BytesMax - tbl_bytes < 38'(q.size)) ? BytesMax
						: tbl_bytes + 38'(q.size);
					expected_rsps.push_back(make_rsp(1, 5'(i), 0, 0, 0, 0, 1));
				end
			end
			msot_pkg::KIND_RETAIN: begin
				a = find_slot(q.address);
				if (a >= 0 && tbl_count[a] < CountMax) tbl_count[a]++;
				expected_rsps.push_back(make_rsp(a >= 0, 0, 0, 0, 0, 0, 1));
			end
			msot_pkg::KIND_RELEASE: begin
				a = find_slot(q.address);
				if (a >= 0 && tbl_count[a] != 0) begin
					tbl_count[a]--;
					expected_rsps.push_back(make_rsp(1, 0, 0, 0, 0, 0, 1));
				end else begin
					expected_rsps.push_back(make_rsp(0, 0, 0, 0, 0, 0, 1));
				end
			end
			msot_pkg::KIND_ADD_REF, msot_pkg::KIND_REM_REF: begin
				a = find_slot(q.address);
				b = find_slot(q.target);
				if (a >= 0 && b >= 0) tbl_edges[a][b] = (q.kind == msot_pkg::KIND_ADD_REF);
				expected_rsps.push_back(make_rsp(a >= 0 && b >= 0, 0, 0, 0, 0, 0, 1));
			end
			msot_pkg::KIND_COLLECT: begin
				if (!gc_enabled) begin
					expected_rsps.push_back(make_rsp(0, 0, 0, 0, 0, 0, 1));
				end else begin
					live = tbl_active;
					marked = '0;
					for (i = 0; i < NObj; i++)
						if (tbl_active[i] && tbl_count[i] != 0) marked[i] = 1'b1;
					do begin
						nxt = marked;
						for (i = 0; i < NObj; i++)
							if (marked[i]) nxt |= tbl_edges[i] & live;
						changed = (nxt != marked);
						marked = nxt;
					end while (changed);
					sweep_slots(live & ~marked);
				end
			end
			msot_pkg::KIND_DETECT: begin
				live = tbl_active;
				do begin
					changed = 0;
					for (i = 0; i < NObj; i++)
						if (live[i] && (tbl_edges[i] & live) == 0) begin
							live[i] = 1'b0;
							changed = 1;
						end
				end while (changed);
				expected_rsps.push_back(make_rsp(1, 0, 0, 0, 0, live != 0, 1));
			end
			default: begin
				sweep_slots('1);
				for (i = 0; i < NObj; i++) tbl_edges[i] = '0;
				tbl_total = '0;
				tbl_bytes = '0;
				expected_rsps[$].object_count = '0;
				expected_rsps[$].held_bytes = '0;
			end
		endcase
	endfunction

	// pick an address: mostly one in use, sometimes null or fresh
	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1 || used_addrs.size() == 0) return $urandom;
		return used_addrs[$urandom_range(0, used_addrs.size() - 1)];
	endfunction

	function automatic req_t random_req();
		req_t q;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) q.kind = msot_pkg::KIND_ALLOC;
		else if (r < 45) q.kind = msot_pkg::KIND_RETAIN;
		else if (r < 55) q.kind = msot_pkg::KIND_RELEASE;
		else if (r < 75) q.kind = msot_pkg::KIND_ADD_REF;
		else if (r < 82) q.kind = msot_pkg::KIND_REM_REF;
		else if (r < 90) q.kind = msot_pkg::KIND_COLLECT;
		else if (r < 97) q.kind = msot_pkg::KIND_DETECT;
		else q.kind = msot_pkg::KIND_DESTROY;
		q.address = pick_addr();
		q.target = pick_addr();
		q.size = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4096);
		if (q.kind == msot_pkg::KIND_ALLOC && q.address != 0 && $urandom_range(0, 3) != 0) begin
			q.address = $urandom;
			if (q.address == 0) q.address = 1;
		end
		return q;
	endfunction

	// typed-in rows still update the shadow so later rows stay predictable
	function automatic void predict_shadow_only(req_t q);
		int n;
		n = expected_rsps.size();
		predict_request(q);
		while (expected_rsps.size() > n) void'(expected_rsps.pop_back());
	endfunction

	// send one request after a random gap; valid stays up until the next gap or drain
	task automatic send_req(req_t q);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {q.size, q.target, q.address};
		s_tuser <= q.kind;
		do @(posedge clk); while (!s_tready);
		if (q.kind == msot_pkg::KIND_ALLOC) used_addrs.push_back(q.address);
		if (use_fixed) expected_rsps.push_back(fixed_rsp);
		else predict_request(q);
		if (use_fixed && q.kind == msot_pkg::KIND_ALLOC) predict_shadow_only(q);
	endtask

	// wait until every response has arrived, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_enable(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		gc_enabled = v;
	endtask

	function automatic req_t mk(msot_pkg::kind_t k, logic [31:0] a, logic [31:0] t,
			logic [31:0] s);
		req_t q;
		q.kind = k; q.address = a; q.target = t; q.size = s;
		return q;
	endfunction

	// response check
	always @(posedge clk) begin
		rsp_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok = m_tdata[0];
			got.slot = m_tdata[5:1];
			got.freed_address = m_tdata[37:6];
			got.collected_count = m_tdata[43:38];
			got.cycle_found = m_tdata[44];
			got.object_count = m_tdata[50:45];
			got.held_bytes = m_tdata[88:51];
			got.freed_flag = m_tuser;
			got.last = m_tlast;
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %p", $time, got);
				errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (got !== exp_r) begin
					$display("%0t: response mismatch, expected %p, actual %p", $time, exp_r, got);
					errors++;
				end
			end
		end
	end

	// receiver: random stall per item, plus one long hold-off
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1;
			end
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("mark_sweep_object_table_unit regression: fail");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t rows[$];
		row_t row;
		req_t q;
		hold_req = 0;
		use_fixed = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		gc_enabled = 1'b1;
		tbl_active = '0; tbl_total = '0; tbl_bytes = '0;
		for (int i = 0; i < NObj; i++) begin
			tbl_addr[i] = '0; tbl_size[i] = '0; tbl_count[i] = '0; tbl_edges[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; fixed ones carry a typed-in response
		row.fixed = 1; row.req = mk(msot_pkg::KIND_RETAIN, 32'h10, 0, 0);
		row.rsp = '{0, 0, 0, 0, 0, 0, 0, 0, 1}; rows.push_back(row);
		row.req = mk(msot_pkg::KIND_ALLOC, 0, 0, 5);
		row.rsp = '{0, 0, 0, 0, 0, 0, 0, 0, 1}; rows.push_back(row);
		row.req = mk(msot_pkg::KIND_ALLOC, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
		row.rsp = '{1, 0, 0, 0, 0, 0, 1, 38'hFFFFFFFF, 1}; rows.push_back(row);
		row.fixed = 0;
		row.req = mk(msot_pkg::KIND_ALLOC, 32'h0000_0001, 0, 32'hFFFFFFFF); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_ALLOC, 32'hAAAA_5555, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_ADD_REF, 32'hFFFFFFFF, 32'h1, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_ADD_REF, 32'h1, 32'h1, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_ADD_REF, 32'h1, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_DETECT, 0, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_REM_REF, 32'h1, 32'h1, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_DETECT, 0, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_RETAIN, 32'hFFFFFFFF, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_RELEASE, 32'hAAAA_5555, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_RELEASE, 32'hFFFFFFFF, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_RETAIN, 32'hFFFFFFFF, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_COLLECT, 0, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_REM_REF, 32'h5555_AAAA, 32'hFFFFFFFF, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_DESTROY, 0, 0, 0); rows.push_back(row);
		row.req = mk(msot_pkg::KIND_DESTROY, 0, 0, 0); rows.push_back(row);
		foreach (rows[r]) begin
			use_fixed = rows[r].fixed;
			fixed_rsp = rows[r].rsp;
			send_req(rows[r].req);
		end
		use_fixed = 0;

		// fill the table and hit the no free slot case
		for (int i = 0; i < NObj + 1; i++)
			send_req(mk(msot_pkg::KIND_ALLOC, 32'h100 + i, 0, 32'h8000_0000));
		send_req(mk(msot_pkg::KIND_DESTROY, 0, 0, 0));
		drain();

		// disabled collector
		write_enable(1'b0);
		send_req(mk(msot_pkg::KIND_ALLOC, 32'h77, 0, 1));
		send_req(mk(msot_pkg::KIND_COLLECT, 0, 0, 0));
		send_req(mk(msot_pkg::KIND_DESTROY, 0, 0, 0));
		drain();
		write_enable(1'b1);

		// random part, with a long receiver hold-off partway through
		for (int n = 0; n < 45; n++) begin
			if (n == 15) hold_req = 1;
			if (n == 25) begin
				drain();
				write_enable($urandom_range(0, 1));
			end
			if (n == 35) begin
				drain();
				write_enable(1'b1);
			end
			q = random_req();
			send_req(q);
		end

		// end of run
		drain();
		if (errors == 0) begin
			$display("mark_sweep_object_table_unit regression: pass");
		end else begin
			$display("mark_sweep_object_table_unit regression: fail");
		end
		$finish;
	end

endmodule
